/* sv/afgc_pkg.sv */
// shared constants, codes and types of the fragment goodput counter
package afgc_pkg;

    localparam int unsigned MAX_PROBE_LEN   = 4095;
    localparam int unsigned GROW_LIMIT      = 800;
    localparam int unsigned FRAG_SIZE_MAX   = 8191;
    localparam int unsigned RESET_FRAG_SIZE = 1600;
    localparam int unsigned SMALL_MIN_HALF  = 4;
    localparam logic [7:0]  BYTE_GOOD       = 8'hFF;
    localparam int unsigned DIV_W           = 32;

    typedef enum logic [2:0] {
        REG_PROBE_LENGTH  = 3'd0,
        REG_START_FRAG    = 3'd1,
        REG_FRAG_OVERHEAD = 3'd2,
        REG_ADAPTIVE_ON   = 3'd3,
        REG_WINDOW        = 3'd4,
        REG_SMALL_PERIOD  = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_BYTE,
        ST_DIV,
        ST_LEFT,
        ST_ACCUM,
        ST_CLEAR,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_SMALL,
        OP_LEFT,
        OP_WIN,
        OP_AVG,
        OP_AVGL,
        OP_AVGS
    } div_op_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

/* sv/afgc_div.sv */
// shared restoring divider, one quotient bit per cycle
module afgc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  afgc_pkg::div_req_t req,
    output afgc_pkg::div_rsp_t rsp
);
    localparam int W  = afgc_pkg::DIV_W;
    localparam int CW = $clog2(W);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]   quot_reg, quot_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   div_reg, div_next;
    logic [W:0]     trial;
    logic [W:0]     diff;

    assign trial = {rem_reg, quot_reg[W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_next  = diff[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b1};
            end else begin
                rem_next  = trial[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

/* sv/adaptive_fragment_goodput_counter.sv */
// top level: probe byte checker, fragment accounting and size adaptation
// a byte inside a packet passes the byte state, and at packet start the start state first; a packet
// start that checks the small-sample period first runs a division on the one shared divider, and
// the last byte runs one for the leftover modulo, then accounting, one for the window check and output,
// with up to three more divisions and a clear on an adaptation boundary; one item at a time
// aresetn is synchronous, active low, and loads the reset values of the registers that have one
module adaptive_fragment_goodput_counter (
    input  logic                aclk,
    input  logic                aresetn,
    // byte items
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_byte_value,
    input  logic                s_byte_present,
    // packet results
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_packet_good_bytes,
    output logic [63:0]         m_total_good_bytes,
    output logic [13:0]         m_frag_size_now,
    // register writes
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_wdata
);
    // configuration registers
    logic [11:0] probe_length_reg;
    logic [7:0]  frag_overhead_reg;
    logic        adaptive_on_reg;
    logic [15:0] window_packets_reg;
    logic [15:0] small_period_reg;

    // packet and window state
    afgc_pkg::state_t  state_reg, state_next;
    afgc_pkg::div_op_t div_op_reg;
    logic [11:0] position_reg;
    logic [12:0] pos_in_frag_reg;
    logic [11:0] frag_index_reg;
    logic        frag_clean_reg;
    logic        prev_clean_reg;
    logic [31:0] pkt_good_reg;
    logic [31:0] pkt_dbl_reg;
    logic [12:0] pkt_frag_size_reg;
    logic [31:0] packet_count_reg;
    logic [63:0] grand_total_reg;
    logic [15:0] win_full_pkts_reg;
    logic [31:0] win_full_bytes_reg;
    logic [31:0] win_dbl_bytes_reg;
    logic [31:0] win_half_bytes_reg;
    logic [15:0] win_half_pkts_reg;
    logic [12:0] cur_frag_size_reg;
    logic        bad_reg;
    logic        half_sel_reg;
    logic [12:0] leftover_reg;
    logic signed [31:0] avg_reg;

    // divider operands
    logic        div_start_reg;
    logic [31:0] div_a_reg;
    logic [31:0] div_b_reg;
    logic        div_neg_reg;

    // output register
    logic        m_valid_reg;
    logic [31:0] out_good_reg;
    logic [63:0] out_total_reg;
    logic [12:0] out_size_reg;

    afgc_pkg::div_req_t div_req;
    afgc_pkg::div_rsp_t div_rsp;

    afgc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_a_reg;
    assign div_req.divisor  = div_b_reg;

    // decisions shared by sequencer and datapath
    logic [11:0] len;
    logic [12:0] count;
    logic        last_byte;
    logic        small_cond;
    logic        win_cond;
    logic        div_done;
    logic signed [31:0] sq;
    logic        grow;
    logic        out_free;
    logic        s_acc;
    logic        div_kick;

    always_comb begin
        len = (probe_length_reg == '0) ? 12'd1 : probe_length_reg;
        if (32'(len) > afgc_pkg::MAX_PROBE_LEN) begin
            len = 12'(afgc_pkg::MAX_PROBE_LEN);
        end
    end

    assign count      = {1'b0, position_reg} + 13'd1;
    assign last_byte  = (count >= {1'b0, len});
    assign small_cond = adaptive_on_reg && (packet_count_reg != '0)
                        && ((cur_frag_size_reg >> 1) > 13'(afgc_pkg::SMALL_MIN_HALF))
                        && (small_period_reg != '0);
    assign win_cond   = adaptive_on_reg && (packet_count_reg != '0)
                        && (window_packets_reg != '0);
    assign div_done   = (state_reg == afgc_pkg::ST_DIV) && div_rsp.done;
    // signed average, truncated toward zero, zero for an empty window
    assign sq         = (div_b_reg == '0) ? 32'sd0
                        : (div_neg_reg ? -$signed(div_rsp.quot) : $signed(div_rsp.quot));
    assign grow       = sq > avg_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign s_acc      = s_valid && s_ready;

    // a divider run is launched in the cycle after this is high
    assign div_kick   = (s_acc && position_reg == '0 && small_cond)
                        || (state_reg == afgc_pkg::ST_BYTE && last_byte)
                        || (div_done && ((div_op_reg == afgc_pkg::OP_WIN && div_rsp.rem == '0)
                            || div_op_reg == afgc_pkg::OP_AVG
                            || (div_op_reg == afgc_pkg::OP_AVGL && !grow
                                && win_half_pkts_reg != '0)))
                        || (state_reg == afgc_pkg::ST_ACCUM && win_cond);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            afgc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (position_reg != '0) begin
                        state_next = afgc_pkg::ST_BYTE;
                    end else if (small_cond) begin
                        state_next = afgc_pkg::ST_DIV;
                    end else begin
                        state_next = afgc_pkg::ST_START;
                    end
                end
            end
            afgc_pkg::ST_START: state_next = afgc_pkg::ST_BYTE;
            afgc_pkg::ST_BYTE: begin
                state_next = last_byte ? afgc_pkg::ST_DIV : afgc_pkg::ST_IDLE;
            end
            afgc_pkg::ST_DIV: begin
                if (div_done) begin
                    unique case (div_op_reg)
                        afgc_pkg::OP_SMALL: state_next = afgc_pkg::ST_START;
                        afgc_pkg::OP_LEFT:  state_next = afgc_pkg::ST_LEFT;
                        afgc_pkg::OP_WIN: begin
                            state_next = (div_rsp.rem == '0) ? afgc_pkg::ST_DIV
                                                             : afgc_pkg::ST_OUT;
                        end
                        afgc_pkg::OP_AVG:   state_next = afgc_pkg::ST_DIV;
                        afgc_pkg::OP_AVGL: begin
                            state_next = (!grow && win_half_pkts_reg != '0)
                                         ? afgc_pkg::ST_DIV : afgc_pkg::ST_CLEAR;
                        end
                        afgc_pkg::OP_AVGS:  state_next = afgc_pkg::ST_CLEAR;
                        default:            state_next = afgc_pkg::ST_CLEAR;
                    endcase
                end
            end
            afgc_pkg::ST_LEFT:  state_next = afgc_pkg::ST_ACCUM;
            afgc_pkg::ST_ACCUM: begin
                state_next = win_cond ? afgc_pkg::ST_DIV : afgc_pkg::ST_OUT;
            end
            afgc_pkg::ST_CLEAR: state_next = afgc_pkg::ST_OUT;
            afgc_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = afgc_pkg::ST_IDLE;
                end
            end
            default: state_next = afgc_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = (state_reg == afgc_pkg::ST_IDLE);
    end

    assign m_valid             = m_valid_reg;
    assign m_packet_good_bytes = $signed(out_good_reg);
    assign m_total_good_bytes  = out_total_reg;
    assign m_frag_size_now     = {1'b0, out_size_reg};

    // per-byte fragment accounting
    logic        fc_b;
    logic        boundary;
    logic [11:0] fi_b;
    logic [12:0] pif_inc;
    logic [31:0] pfs_ext;
    logic [31:0] ov_ext;
    logic [13:0] dbl_size;

    assign fc_b     = frag_clean_reg && !bad_reg;
    assign boundary = (position_reg != '0) && (pos_in_frag_reg == '0);
    assign fi_b     = frag_index_reg + 12'd1;
    assign pif_inc  = pos_in_frag_reg + 13'd1;
    assign pfs_ext  = {19'd0, pkt_frag_size_reg};
    assign ov_ext   = {24'd0, frag_overhead_reg};
    assign dbl_size = {cur_frag_size_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= afgc_pkg::ST_IDLE;
            div_op_reg          <= afgc_pkg::OP_SMALL;
            div_start_reg       <= 1'b0;
            m_valid_reg         <= 1'b0;
            probe_length_reg    <= 12'd1;
            frag_overhead_reg   <= 8'd4;
            adaptive_on_reg     <= 1'b0;
            window_packets_reg  <= 16'd1;
            small_period_reg    <= 16'd10;
            position_reg        <= '0;
            pos_in_frag_reg     <= '0;
            frag_index_reg      <= '0;
            frag_clean_reg      <= 1'b1;
            prev_clean_reg      <= 1'b0;
            pkt_good_reg        <= '0;
            pkt_dbl_reg         <= '0;
            pkt_frag_size_reg   <= 13'(afgc_pkg::RESET_FRAG_SIZE);
            packet_count_reg    <= '0;
            grand_total_reg     <= '0;
            win_full_pkts_reg   <= '0;
            win_full_bytes_reg  <= '0;
            win_dbl_bytes_reg   <= '0;
            win_half_bytes_reg  <= '0;
            win_half_pkts_reg   <= '0;
            cur_frag_size_reg   <= 13'(afgc_pkg::RESET_FRAG_SIZE);
            half_sel_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= div_kick;
            // result register loads in the output state, else empties on a take
            if (state_reg == afgc_pkg::ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // register writes
            if (cfg_we) begin
                unique case (cfg_index)
                    afgc_pkg::REG_PROBE_LENGTH:  probe_length_reg  <= cfg_wdata[11:0];
                    afgc_pkg::REG_START_FRAG: begin
                        cur_frag_size_reg   <= (cfg_wdata[12:0] == '0) ? 13'd1
                                                                       : cfg_wdata[12:0];
                    end
                    afgc_pkg::REG_FRAG_OVERHEAD: frag_overhead_reg <= cfg_wdata[7:0];
                    afgc_pkg::REG_ADAPTIVE_ON:   adaptive_on_reg   <= cfg_wdata[0];
                    afgc_pkg::REG_WINDOW:        window_packets_reg <= cfg_wdata;
                    afgc_pkg::REG_SMALL_PERIOD:  small_period_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            unique case (state_reg)
                afgc_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        bad_reg      <= !s_byte_present || (s_byte_value != afgc_pkg::BYTE_GOOD);
                        half_sel_reg <= 1'b0;
                        if (position_reg == '0 && small_cond) begin
                            // is this packet a half-size sample
                            div_op_reg    <= afgc_pkg::OP_SMALL;
                            div_a_reg     <= packet_count_reg;
                            div_b_reg     <= {16'd0, small_period_reg};
                            div_neg_reg   <= 1'b0;
                        end
                    end
                end
                afgc_pkg::ST_START: begin
                    pkt_frag_size_reg <= half_sel_reg ? (cur_frag_size_reg >> 1)
                                                      : cur_frag_size_reg;
                    packet_count_reg  <= packet_count_reg + 32'd1;
                    pos_in_frag_reg   <= '0;
                    frag_index_reg    <= '0;
                    frag_clean_reg    <= 1'b1;
                    prev_clean_reg    <= 1'b0;
                    pkt_good_reg      <= '0;
                    pkt_dbl_reg       <= '0;
                end
                afgc_pkg::ST_BYTE: begin
                    if (boundary) begin
                        // a fragment closes on this byte
                        frag_index_reg <= fi_b;
                        if (pkt_frag_size_reg == cur_frag_size_reg && !fi_b[0]
                            && fc_b && prev_clean_reg) begin
                            pkt_dbl_reg <= pkt_dbl_reg + {pfs_ext[30:0], 1'b0} - ov_ext;
                        end
                        if (fc_b) begin
                            pkt_good_reg <= pkt_good_reg + pfs_ext - ov_ext;
                        end
                        prev_clean_reg <= fc_b;
                        frag_clean_reg <= 1'b1;
                    end else begin
                        frag_clean_reg <= fc_b;
                    end
                    pos_in_frag_reg <= (pif_inc >= pkt_frag_size_reg) ? 13'd0 : pif_inc;
                    if (last_byte) begin
                        div_op_reg    <= afgc_pkg::OP_LEFT;
                        div_a_reg     <= {19'd0, count};
                        div_b_reg     <= pfs_ext;
                        div_neg_reg   <= 1'b0;
                    end else begin
                        position_reg <= count[11:0];
                    end
                end
                afgc_pkg::ST_DIV: begin
                    if (div_done) begin
                        unique case (div_op_reg)
                            afgc_pkg::OP_SMALL: half_sel_reg <= (div_rsp.rem == '0);
                            afgc_pkg::OP_LEFT:  leftover_reg <= div_rsp.rem[12:0];
                            afgc_pkg::OP_WIN: begin
                                if (div_rsp.rem == '0) begin
                                    div_op_reg    <= afgc_pkg::OP_AVG;
                                    div_neg_reg   <= win_full_bytes_reg[31];
                                    div_a_reg     <= win_full_bytes_reg[31]
                                                     ? -win_full_bytes_reg
                                                     : win_full_bytes_reg;
                                    div_b_reg     <= {16'd0, win_full_pkts_reg};
                                end
                            end
                            afgc_pkg::OP_AVG: begin
                                avg_reg       <= sq;
                                div_op_reg    <= afgc_pkg::OP_AVGL;
                                div_neg_reg   <= win_dbl_bytes_reg[31];
                                div_a_reg     <= win_dbl_bytes_reg[31]
                                                 ? -win_dbl_bytes_reg : win_dbl_bytes_reg;
                                div_b_reg     <= {16'd0, win_full_pkts_reg};
                            end
                            afgc_pkg::OP_AVGL: begin
                                if (grow) begin
                                    if (32'(cur_frag_size_reg) <= afgc_pkg::GROW_LIMIT) begin
                                        cur_frag_size_reg <=
                                            (32'(dbl_size) > afgc_pkg::FRAG_SIZE_MAX)
                                            ? 13'(afgc_pkg::FRAG_SIZE_MAX) : dbl_size[12:0];
                                    end
                                end else if (win_half_pkts_reg != '0) begin
                                    div_op_reg    <= afgc_pkg::OP_AVGS;
                                    div_neg_reg   <= win_half_bytes_reg[31];
                                    div_a_reg     <= win_half_bytes_reg[31]
                                                     ? -win_half_bytes_reg
                                                     : win_half_bytes_reg;
                                    div_b_reg     <= {16'd0, win_half_pkts_reg};
                                end
                            end
                            afgc_pkg::OP_AVGS: begin
                                if ((cur_frag_size_reg >> 1) > 13'd1
                                    && (avg_reg == 32'sd0 || sq > avg_reg)) begin
                                    cur_frag_size_reg <= cur_frag_size_reg >> 1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                afgc_pkg::ST_LEFT: begin
                    // partial fragment at the end of the packet
                    if (leftover_reg != '0 && frag_clean_reg) begin
                        if (pkt_frag_size_reg == cur_frag_size_reg && frag_index_reg[0]) begin
                            if (prev_clean_reg) begin
                                pkt_dbl_reg <= pkt_dbl_reg + pfs_ext
                                               + {19'd0, leftover_reg} - ov_ext;
                            end
                        end else begin
                            pkt_dbl_reg <= pkt_dbl_reg + {19'd0, leftover_reg} - ov_ext;
                        end
                        pkt_good_reg <= pkt_good_reg + {19'd0, leftover_reg} - ov_ext;
                    end
                end
                afgc_pkg::ST_ACCUM: begin
                    grand_total_reg <= grand_total_reg + {{32{pkt_good_reg[31]}}, pkt_good_reg};
                    position_reg    <= '0;
                    if (pkt_frag_size_reg == cur_frag_size_reg) begin
                        win_full_pkts_reg  <= win_full_pkts_reg + 16'd1;
                        win_full_bytes_reg <= win_full_bytes_reg + pkt_good_reg;
                        win_dbl_bytes_reg  <= win_dbl_bytes_reg + pkt_dbl_reg;
                    end else begin
                        win_half_pkts_reg  <= win_half_pkts_reg + 16'd1;
                        win_half_bytes_reg <= win_half_bytes_reg + pkt_good_reg;
                    end
                    if (win_cond) begin
                        // window boundary check
                        div_op_reg    <= afgc_pkg::OP_WIN;
                        div_a_reg     <= packet_count_reg;
                        div_b_reg     <= {16'd0, window_packets_reg};
                        div_neg_reg   <= 1'b0;
                    end
                end
                afgc_pkg::ST_CLEAR: begin
                    win_full_pkts_reg  <= '0;
                    win_full_bytes_reg <= '0;
                    win_dbl_bytes_reg  <= '0;
                    win_half_bytes_reg <= '0;
                    win_half_pkts_reg  <= '0;
                end
                afgc_pkg::ST_OUT: begin
                    if (out_free) begin
                        out_good_reg  <= pkt_good_reg;
                        out_total_reg <= grand_total_reg;
                        out_size_reg  <= cur_frag_size_reg;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* sv/afgc_checker.sv */
// port-level checks of the fragment goodput counter and their binding
module afgc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_total_good_bytes,
    input logic [13:0] m_frag_size_now
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_total_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_total_good_bytes))
        else $error("running total changed while stalled");

    a_size_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frag_size_now != 14'd0)
        else $error("fragment size reported as zero");

    a_busy_after_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after an accepted item");

endmodule

bind adaptive_fragment_goodput_counter afgc_checker u_afgc_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_total_good_bytes (m_total_good_bytes),
    .m_frag_size_now    (m_frag_size_now)
);
